FILE: src/tcw_pkg.sv
// Shared types, codes and width helpers for the texel coordinate wrap unit.
package tcw_pkg;

  localparam int DEF_MAX_SIZE   = 16384;
  localparam int DEF_COORD_BITS = 16;
  localparam int OUT_BITS       = 16;
  localparam int CFG_DATA_BITS  = 15;
  localparam int CFG_IDX_BITS   = 3;
  localparam int MODE_BITS      = 3;
  localparam int NUM_AXES       = 3;
  // remainder steps per divider stage
  localparam int DIV_STEP       = 4;

  typedef enum logic [MODE_BITS-1:0] {
    WRAP_REPEAT        = 3'd0,
    WRAP_BORDER        = 3'd1,
    WRAP_EDGE          = 3'd2,
    WRAP_MIRROR_REPEAT = 3'd3,
    WRAP_MIRROR_EDGE   = 3'd4
  } wrap_mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MODE_X = 3'd0,
    REG_MODE_Y = 3'd1,
    REG_MODE_Z = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5
  } cfg_reg_t;

  // divisor width: holds 2 * max_size
  function automatic int div_width(input int max_size);
    return $clog2(2 * max_size) + 1;
  endfunction

  // signed width of wrapped values and clamp arithmetic
  function automatic int val_width(input int max_size, input int coord_bits);
    int w;
    w = div_width(max_size) + 1;
    if (coord_bits + 1 > w) w = coord_bits + 1;
    if (OUT_BITS > w) w = OUT_BITS;
    return w;
  endfunction

endpackage

FILE: src/tcw_if.sv
// Handshake channel interfaces: coordinate input, result output, config write.
interface tcw_coord_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface tcw_result_if;
  import tcw_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] wrapped_x;
  logic signed [OUT_BITS-1:0] wrapped_y;
  logic signed [OUT_BITS-1:0] wrapped_z;
  logic                       on_border;

  modport source (output valid, wrapped_x, wrapped_y, wrapped_z, on_border, input ready);
  modport sink (input valid, wrapped_x, wrapped_y, wrapped_z, on_border, output ready);
endinterface

interface tcw_cfg_if;
  import tcw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/tcw_axis.sv
// One axis of the wrap pipeline: entry, pipelined remainder, sign fix, mode select.
module tcw_axis import tcw_pkg::*; #(
  parameter int MAX_SIZE   = DEF_MAX_SIZE,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int DW         = div_width(MAX_SIZE),
  parameter int XW         = val_width(MAX_SIZE, COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         en,
  input  wrap_mode_t                   mode,
  input  logic [DW-1:0]                size,
  input  logic signed [COORD_BITS-1:0] coord,
  output logic signed [XW-1:0]         wrapped,
  output logic [DW-1:0]                size_out
);

  localparam int NDIV = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int MPW  = NDIV * DIV_STEP;

  // entry stage logic
  logic signed [XW-1:0] cx;
  logic signed [XW-1:0] sx;
  logic signed [XW-1:0] abs_x;
  logic signed [XW-1:0] clmp_nxt;
  logic [DW-1:0]        dvsr_nxt;
  logic                 neg;

  // per-stage registers; index 0 is the entry register
  logic [MPW-1:0]       mag_r  [NDIV];
  logic [DW-1:0]        rem_r  [NDIV+1];
  logic [DW-1:0]        dvsr_r [NDIV+1];
  logic [DW-1:0]        size_r [NDIV+1];
  wrap_mode_t           mode_r [NDIV+1];
  logic                 neg_r  [NDIV+1];
  logic signed [XW-1:0] clmp_r [NDIV+1];

  always_comb begin
    cx    = XW'(coord);
    sx    = signed'(XW'(size));
    neg   = coord[COORD_BITS-1];
    abs_x = neg ? -cx : cx;
    dvsr_nxt = (mode == WRAP_MIRROR_REPEAT) ? {size[DW-2:0], 1'b0} : size;
    unique case (mode)
      WRAP_BORDER: begin
        if (cx < -XW'(1))       clmp_nxt = -XW'(1);
        else if (cx > sx)       clmp_nxt = sx;
        else                    clmp_nxt = cx;
      end
      WRAP_EDGE: begin
        if (neg)                      clmp_nxt = '0;
        else if (cx > sx - XW'(1))    clmp_nxt = sx - XW'(1);
        else                          clmp_nxt = cx;
      end
      WRAP_MIRROR_EDGE: begin
        // mirror of a negative a is -(1+a), i.e. ~a
        if (neg) begin
          if (~cx > sx - XW'(1))      clmp_nxt = sx - XW'(1);
          else                        clmp_nxt = ~cx;
        end else if (cx > sx - XW'(1)) begin
          clmp_nxt = sx - XW'(1);
        end else begin
          clmp_nxt = cx;
        end
      end
      default:                  clmp_nxt = cx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0]  <= MPW'(unsigned'(abs_x));
      rem_r[0]  <= '0;
      dvsr_r[0] <= dvsr_nxt;
      size_r[0] <= size;
      mode_r[0] <= mode;
      neg_r[0]  <= neg;
      clmp_r[0] <= clmp_nxt;
    end
  end

  // restoring remainder, DIV_STEP magnitude bits per stage, MSB first
  for (genvar k = 1; k <= NDIV; k++) begin : g_div
    logic [DW-1:0]  rem_c;
    logic [MPW-1:0] mag_c;
    logic [DW:0]    trial;

    always_comb begin
      rem_c = rem_r[k-1];
      mag_c = mag_r[k-1];
      trial = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {rem_c, mag_c[MPW-1]};
        if (trial >= {1'b0, dvsr_r[k-1]}) trial = trial - {1'b0, dvsr_r[k-1]};
        rem_c = trial[DW-1:0];
        mag_c = mag_c << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_c;
        dvsr_r[k] <= dvsr_r[k-1];
        size_r[k] <= size_r[k-1];
        mode_r[k] <= mode_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        clmp_r[k] <= clmp_r[k-1];
      end
    end

    if (k < NDIV) begin : g_mag
      always_ff @(posedge clk) begin
        if (en) mag_r[k] <= mag_c;
      end
    end
  end

  // sign fix: positive modulo of a negative coordinate
  logic [DW-1:0]        fix_nxt;
  logic [DW-1:0]        fix_r;
  logic [DW-1:0]        fdvsr_r;
  logic [DW-1:0]        fsize_r;
  wrap_mode_t           fmode_r;
  logic signed [XW-1:0] fclmp_r;

  assign fix_nxt = (neg_r[NDIV] && rem_r[NDIV] != '0) ? dvsr_r[NDIV] - rem_r[NDIV]
                                                      : rem_r[NDIV];

  always_ff @(posedge clk) begin
    if (en) begin
      fix_r   <= fix_nxt;
      fdvsr_r <= dvsr_r[NDIV];
      fsize_r <= size_r[NDIV];
      fmode_r <= mode_r[NDIV];
      fclmp_r <= clmp_r[NDIV];
    end
  end

  // mode select; mirrored repeat folds m >= size back as 2*size-1-m
  logic [DW-1:0]        mir;
  logic signed [XW-1:0] wrapped_nxt;
  logic signed [XW-1:0] wrapped_r;
  logic [DW-1:0]        osize_r;

  always_comb begin
    mir = (fix_r < fsize_r) ? fix_r : fdvsr_r - DW'(1) - fix_r;
    unique case (fmode_r)
      WRAP_MIRROR_REPEAT: wrapped_nxt = signed'(XW'(mir));
      WRAP_BORDER,
      WRAP_EDGE,
      WRAP_MIRROR_EDGE:   wrapped_nxt = fclmp_r;
      default:            wrapped_nxt = signed'(XW'(fix_r));
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wrapped_r <= wrapped_nxt;
      osize_r   <= fsize_r;
    end
  end

  assign wrapped  = wrapped_r;
  assign size_out = osize_r;

endmodule

FILE: src/texel_coordinate_wrap_unit.sv
// Top level of the texel coordinate wrap unit: config registers, axis pipelines, handshake.
//
//  channel   dir  handshake               word
//  in_chan   in   valid/ready             coord_x, coord_y, coord_z
//  out_chan  out  valid/ready             wrapped_x, wrapped_y, wrapped_z, on_border
//  cfg_chan  in   valid/ready (ready = 1) index, data
//
// One word per cycle unless an output word that is not taken stalls the pipeline;
// the remainder pipeline takes four bits per stage.
// Reset clears the valid bits and sets modes to repeat, sizes to 1.
// A stall at the output freezes every stage at once; nothing is dropped or repeated.
module texel_coordinate_wrap_unit import tcw_pkg::*; #(
  parameter int MAX_SIZE   = DEF_MAX_SIZE,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  tcw_cfg_if.sink      cfg_chan,
  tcw_coord_if.sink    in_chan,
  tcw_result_if.source out_chan
);

  localparam int DW   = div_width(MAX_SIZE);
  localparam int XW   = val_width(MAX_SIZE, COORD_BITS);
  localparam int NDIV = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int LAT  = NDIV + 3;

  // configuration, sizes held already limited to 1..MAX_SIZE
  wrap_mode_t    cmode_r [NUM_AXES];
  logic [DW-1:0] csize_r [NUM_AXES];
  logic [DW-1:0] size_wr;
  wrap_mode_t    mode_wr;

  always_comb begin
    mode_wr = wrap_mode_t'(cfg_chan.data[MODE_BITS-1:0]);
    if (cfg_chan.data == '0)                      size_wr = DW'(1);
    else if (32'(cfg_chan.data) > 32'(MAX_SIZE))  size_wr = DW'(MAX_SIZE);
    else                                          size_wr = DW'(cfg_chan.data);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        cmode_r[k] <= WRAP_REPEAT;
        csize_r[k] <= DW'(1);
      end
    end else if (cfg_chan.valid) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        REG_MODE_X: cmode_r[0] <= mode_wr;
        REG_MODE_Y: cmode_r[1] <= mode_wr;
        REG_MODE_Z: cmode_r[2] <= mode_wr;
        REG_SIZE_X: csize_r[0] <= size_wr;
        REG_SIZE_Y: csize_r[1] <= size_wr;
        REG_SIZE_Z: csize_r[2] <= size_wr;
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  // pipeline advance and valid chain
  logic           en;
  logic [LAT-1:0] v_r;

  assign en            = !v_r[LAT-1] || out_chan.ready;
  assign in_chan.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[LAT-2:0], in_chan.valid};
  end

  logic signed [COORD_BITS-1:0] coord_a [NUM_AXES];
  logic signed [XW-1:0]         w_a     [NUM_AXES];
  logic [DW-1:0]                s_a     [NUM_AXES];
  logic [NUM_AXES-1:0]          bd;
  logic [NUM_AXES-1:0]          in_rng;

  assign coord_a[0] = in_chan.coord_x;
  assign coord_a[1] = in_chan.coord_y;
  assign coord_a[2] = in_chan.coord_z;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    tcw_axis #(
      .MAX_SIZE   (MAX_SIZE),
      .COORD_BITS (COORD_BITS),
      .DW         (DW),
      .XW         (XW)
    ) u_axis (
      .clk      (clk),
      .en       (en),
      .mode     (cmode_r[k]),
      .size     (csize_r[k]),
      .coord    (coord_a[k]),
      .wrapped  (w_a[k]),
      .size_out (s_a[k])
    );

    // size travels with the word, so the flag matches the size it was wrapped with
    assign bd[k]     = (w_a[k] == '1) || (w_a[k] == signed'(XW'(s_a[k])));
    assign in_rng[k] = (w_a[k] == '1) || (!w_a[k][XW-1] && XW'(s_a[k]) >= XW'(w_a[k]));
  end

  assign out_chan.valid     = v_r[LAT-1];
  assign out_chan.wrapped_x = w_a[0][OUT_BITS-1:0];
  assign out_chan.wrapped_y = w_a[1][OUT_BITS-1:0];
  assign out_chan.wrapped_z = w_a[2][OUT_BITS-1:0];
  assign out_chan.on_border = |bd;

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAT-1] |-> (&in_rng))
    else $error("wrapped coordinate outside -1..size");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("pipeline moved during stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && v_r[LAT-2] |=> v_r[LAT-1])
    else $error("word lost on its way to the output register");

endmodule

FILE: tb/tcw_wrap_checker.sv
`timescale 1ns / 100ps
// Watches the config, coordinate and result channels, predicts each wrapped word and compares.
module tcw_wrap_checker import tcw_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  tcw_cfg_if     cfg_bus,
  tcw_coord_if   coord_bus,
  tcw_result_if  result_bus,
  output int     mismatch_cnt,
  output int     pending_cnt,
  output int     checked_cnt
);

  localparam int REPORT_MAX = 40;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
    logic                       border;
  } wrap_word_t;

  logic [MODE_BITS-1:0]     axis_mode [NUM_AXES];
  logic [CFG_DATA_BITS-1:0] axis_size [NUM_AXES];
  wrap_word_t               pending_wraps [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic int clamp_to(input int a, input int lo, input int hi);
    if (a < lo) return lo;
    if (a > hi) return hi;
    return a;
  endfunction

  function automatic int mod_pos(input int a, input int m);
    int r;
    r = a % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic int fold_neg(input int a);
    return (a >= 0) ? a : -1 - a;
  endfunction

  // size register as the datapath sees it: 0 counts as 1, above max saturates
  function automatic int texels_of(input logic [CFG_DATA_BITS-1:0] s);
    if (s == '0) return 1;
    if (int'(s) > DEF_MAX_SIZE) return DEF_MAX_SIZE;
    return int'(s);
  endfunction

  function automatic int wrap_coord(input logic [MODE_BITS-1:0] mode, input int span,
                                    input int c);
    case (mode)
      WRAP_BORDER:        return clamp_to(c, -1, span);
      WRAP_EDGE:          return clamp_to(c, 0, span - 1);
      WRAP_MIRROR_REPEAT: return (span - 1) - fold_neg(mod_pos(c, 2 * span) - span);
      WRAP_MIRROR_EDGE:   return clamp_to(fold_neg(c), 0, span - 1);
      default:            return mod_pos(c, span);  // repeat, and the spare codes
    endcase
  endfunction

  function automatic wrap_word_t predict_wrap(input int cx, input int cy, input int cz);
    wrap_word_t word;
    int         c [NUM_AXES];
    int         w [NUM_AXES];
    int         span;
    c = '{cx, cy, cz};
    word.border = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      span = texels_of(axis_size[i]);
      w[i] = wrap_coord(axis_mode[i], span, c[i]);
      if (w[i] == -1 || w[i] == span) word.border = 1'b1;
    end
    word.x = w[0][OUT_BITS-1:0];
    word.y = w[1][OUT_BITS-1:0];
    word.z = w[2][OUT_BITS-1:0];
    return word;
  endfunction

  always @(posedge clk) begin : watch
    wrap_word_t got;
    wrap_word_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_mode[i] = WRAP_REPEAT;
        axis_size[i] = 1;
      end
      pending_wraps.delete();
      pending_cnt = 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          REG_MODE_X: axis_mode[0] = cfg_bus.data[MODE_BITS-1:0];
          REG_MODE_Y: axis_mode[1] = cfg_bus.data[MODE_BITS-1:0];
          REG_MODE_Z: axis_mode[2] = cfg_bus.data[MODE_BITS-1:0];
          REG_SIZE_X: axis_size[0] = cfg_bus.data;
          REG_SIZE_Y: axis_size[1] = cfg_bus.data;
          REG_SIZE_Z: axis_size[2] = cfg_bus.data;
          default: ;  // unmapped index: dropped
        endcase
      end
      if (coord_bus.valid && coord_bus.ready)
        pending_wraps.push_back(predict_wrap(coord_bus.coord_x, coord_bus.coord_y,
                                             coord_bus.coord_z));
      if (result_bus.valid && result_bus.ready) begin
        got.x      = result_bus.wrapped_x;
        got.y      = result_bus.wrapped_y;
        got.z      = result_bus.wrapped_z;
        got.border = result_bus.on_border;
        checked_cnt++;
        if (pending_wraps.size() == 0) begin
          report_mismatch("result word with nothing pending", got.x, 0);
        end else begin
          want = pending_wraps.pop_front();
          if (got.x !== want.x) report_mismatch("wrapped_x", got.x, want.x);
          if (got.y !== want.y) report_mismatch("wrapped_y", got.y, want.y);
          if (got.z !== want.z) report_mismatch("wrapped_z", got.z, want.z);
          if (got.border !== want.border)
            report_mismatch("on_border", got.border, want.border);
        end
      end
      pending_cnt = pending_wraps.size();
    end
  end

endmodule

FILE: tb/tb_texel_coordinate_wrap_unit.sv
`timescale 1ns / 100ps
// Top of the texel coordinate wrap unit bench: clock, reset, stimulus, back-pressure, verdict.
module tb_texel_coordinate_wrap_unit import tcw_pkg::*; ();

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int IDLE_MAX        = 16;
  localparam int HOLD_CYCLES     = 200;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 50;
  localparam int HOLD_PHASE      = 3;
  localparam int PAUSE_PHASE     = 7;
  localparam int COORD_MIN       = -32768;
  localparam int COORD_MAX       = 32767;
  localparam int SIZE_FIELD_MAX  = (1 << CFG_DATA_BITS) - 1;

  localparam logic [MODE_BITS-1:0]    MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_BITS-1:0]    MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_BITS-1:0]    MODE_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6  = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7  = 3'd7;

  logic clk;
  logic rst_n;

  tcw_coord_if #(.COORD_BITS(DEF_COORD_BITS)) coord_ch ();
  tcw_result_if                               result_ch ();
  tcw_cfg_if                                  cfg_ch ();

  texel_coordinate_wrap_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_ch),
    .in_chan  (coord_ch),
    .out_chan (result_ch)
  );

  int mismatches;
  int pending;
  int checked;

  tcw_wrap_checker wrap_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_bus      (cfg_ch),
    .coord_bus    (coord_ch),
    .result_bus   (result_ch),
    .mismatch_cnt (mismatches),
    .pending_cnt  (pending),
    .checked_cnt  (checked)
  );

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_off_req;
  int words_sent;
  int reg_writes;
  int settings_run;
  int axis_span [NUM_AXES];
  int idle_cycles;

  cfg_reg_t mode_reg_of [NUM_AXES] = '{REG_MODE_X, REG_MODE_Y, REG_MODE_Z};
  cfg_reg_t size_reg_of [NUM_AXES] = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
  logic [MODE_BITS-1:0] mode_menu [8] = '{WRAP_REPEAT, WRAP_BORDER, WRAP_EDGE,
                                          WRAP_MIRROR_REPEAT, WRAP_MIRROR_EDGE,
                                          MODE_SPARE_5, MODE_SPARE_6, MODE_SPARE_7};
  int size_menu [5] = '{0, 1, DEF_MAX_SIZE, DEF_MAX_SIZE + 1, SIZE_FIELD_MAX};

  always begin
    clk = 1'b0;
    #(HALF_PERIOD);
    clk = 1'b1;
    #(HALF_PERIOD);
  end

  // watchdog: cycles without any handshake on any channel
  always @(posedge clk) begin
    if (!rst_n || (coord_ch.valid && coord_ch.ready) || (result_ch.valid && result_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d words pending", idle_cycles, pending);
      $display("texel_coordinate_wrap_unit regression: fail");
      $finish;
    end
  end

  // result side: random gaps per word, one long hold-off on request
  initial begin : result_sink
    int gap;
    result_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      if (hold_off_req) begin
        gap = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // call at a falling edge; leaves valid high for a back-to-back write
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic close_cfg();
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    settings_run++;
  endtask

  task automatic set_axis(input int axis, input logic [MODE_BITS-1:0] mode,
                          input int size, input logic [CFG_DATA_BITS-MODE_BITS-1:0] junk);
    write_reg(mode_reg_of[axis], {junk, mode});
    write_reg(size_reg_of[axis], size[CFG_DATA_BITS-1:0]);
    if (size == 0)
      axis_span[axis] = 1;
    else if (size > DEF_MAX_SIZE)
      axis_span[axis] = DEF_MAX_SIZE;
    else
      axis_span[axis] = size;
  endtask

  task automatic push_coord(input int cx, input int cy, input int cz);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      coord_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    coord_ch.coord_x <= cx[DEF_COORD_BITS-1:0];
    coord_ch.coord_y <= cy[DEF_COORD_BITS-1:0];
    coord_ch.coord_z <= cz[DEF_COORD_BITS-1:0];
    coord_ch.valid   <= 1'b1;
    do @(posedge clk); while (!coord_ch.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic end_burst();
    coord_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  // mostly near the texture, some extremes and some full-range noise
  function automatic int pick_coord(input int span);
    int c;
    case ($urandom_range(0, 7))
      0: c = int'($urandom_range(0, 65535)) + COORD_MIN;
      1: begin
        case ($urandom_range(0, 5))
          0: c = COORD_MIN;
          1: c = COORD_MAX;
          2: c = -1;
          3: c = span;
          4: c = -span - 1;
          default: c = 2 * span;
        endcase
      end
      default: c = int'($urandom_range(0, 6 * span + 4)) - 3 * span - 2;
    endcase
    if (c < COORD_MIN) c = COORD_MIN;
    if (c > COORD_MAX) c = COORD_MAX;
    return c;
  endfunction

  task automatic random_setting();
    int size;
    int pick;
    for (int i = 0; i < NUM_AXES; i++) begin
      pick = $urandom_range(0, 11);
      case ($urandom_range(0, 15))
        0:       size = size_menu[$urandom_range(0, 4)];
        1, 2:    size = $urandom_range(0, SIZE_FIELD_MAX);
        3, 4, 5: size = $urandom_range(1, 512);
        default: size = $urandom_range(1, 16);
      endcase
      set_axis(i, (pick < 10) ? mode_menu[pick % 5] : mode_menu[$urandom_range(5, 7)],
               size, (CFG_DATA_BITS-MODE_BITS)'($urandom_range(0, 4095)));
    end
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                CFG_DATA_BITS'($urandom_range(0, SIZE_FIELD_MAX)));
    close_cfg();
  endtask

  initial begin : stimulus
    rst_n            = 1'b0;
    coord_ch.valid   = 1'b0;
    coord_ch.coord_x = '0;
    coord_ch.coord_y = '0;
    coord_ch.coord_z = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    tx_idle_on       = 1'b0;
    rx_idle_on       = 1'b0;
    hold_off_req     = 1'b0;
    axis_span        = '{1, 1, 1};
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: repeat with one texel on every axis
    push_coord(COORD_MIN, COORD_MAX, 0);
    push_coord(-1, 1, COORD_MIN);
    end_burst();
    wait_drained();

    set_axis(0, WRAP_BORDER, 5, '0);
    set_axis(1, WRAP_EDGE, 7, '0);
    set_axis(2, WRAP_MIRROR_REPEAT, 3, '0);
    close_cfg();
    push_coord(COORD_MIN, COORD_MIN, COORD_MIN);
    push_coord(COORD_MAX, COORD_MAX, COORD_MAX);
    push_coord(-1, -1, -1);
    push_coord(5, 7, 3);
    push_coord(4, 6, 2);
    push_coord(-2, 0, -4);
    push_coord(6, 8, 6);
    push_coord(0, -9, -7);
    end_burst();
    wait_drained();

    // size 0 acts as 1, oversize saturates, spare mode code acts as repeat,
    // unmapped register indexes are dropped
    set_axis(0, WRAP_MIRROR_EDGE, DEF_MAX_SIZE, '0);
    set_axis(1, MODE_SPARE_7, 0, '0);
    set_axis(2, WRAP_REPEAT, SIZE_FIELD_MAX, '0);
    write_reg(REG_SPARE_6, 15'h0001);
    write_reg(REG_SPARE_7, 15'h7FFF);
    close_cfg();
    push_coord(COORD_MIN, COORD_MIN, COORD_MIN);
    push_coord(COORD_MAX, COORD_MAX, COORD_MAX);
    push_coord(-16385, 5, -16384);
    push_coord(16384, -1, 16383);
    push_coord(-1, 0, -1);
    push_coord(16383, 1, 16384);
    end_burst();
    wait_drained();

    // upper data bits of the mode registers set, must not leak into the mode
    set_axis(0, WRAP_MIRROR_REPEAT, DEF_MAX_SIZE, '1);
    set_axis(1, WRAP_BORDER, DEF_MAX_SIZE, '1);
    set_axis(2, WRAP_EDGE, 1, '1);
    close_cfg();
    push_coord(COORD_MIN, -1, COORD_MIN);
    push_coord(COORD_MAX, 16384, COORD_MAX);
    push_coord(16383, -2, 0);
    push_coord(-16385, 16385, 1);
    end_burst();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      random_setting();
      case (p)
        0: begin
          tx_idle_on = 1'b0;
          rx_idle_on = 1'b0;
        end
        1: begin
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b1;
        end
        default: begin
          tx_idle_on = ($urandom_range(0, 2) != 0);
          rx_idle_on = ($urandom_range(0, 2) != 0);
        end
      endcase
      // sender streams while the result side sits on a long hold-off
      if (p == HOLD_PHASE) begin
        tx_idle_on   = 1'b0;
        hold_off_req = 1'b1;
      end
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (p == PAUSE_PHASE && k == WORDS_PER_PHASE / 2) begin
          end_burst();
          wait_drained();
        end
        push_coord(pick_coord(axis_span[0]), pick_coord(axis_span[1]),
                   pick_coord(axis_span[2]));
      end
      end_burst();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d coordinate words, checked %0d results, %0d register writes over %0d settings.",
             words_sent, checked, reg_writes, settings_run);
    $display("All wrap modes and spare codes, sizes 0 to %0d, input stalls and output hold-off.",
             SIZE_FIELD_MAX);
    if (mismatches == 0)
      $display("texel_coordinate_wrap_unit regression: pass");
    else
      $display("texel_coordinate_wrap_unit regression: fail");
    $finish;
  end

endmodule
